@@ src/alrm_pkg.sv @@
// shared widths and types for the arrival latency and reorder monitor
package alrm_pkg;

  localparam int TIME_BITS = 48;
  localparam int SRC_BITS  = 8;
  localparam int SOURCES   = 1 << SRC_BITS;
  localparam int LAT_BITS  = TIME_BITS + 1;
  localparam int CNT_BITS  = 32;

  localparam int IN_BITS   = 2 * TIME_BITS + SRC_BITS;
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = 3 * LAT_BITS + 3 * CNT_BITS;
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [SRC_BITS-1:0]  src_t;
  typedef logic [LAT_BITS-1:0]  lat_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  typedef struct packed {
    logic  seen;
    time_t latest;
  } src_look_t;

  typedef struct packed {
    logic fire;
    lat_t lat;
    logic pair;
    logic inv;
  } stat_upd_t;

  typedef struct packed {
    lat_t min_lat;
    lat_t max_lat;
    cnt_t delivered;
    cnt_t pairs;
    cnt_t inversions;
  } stat_out_t;

endpackage

@@ src/alrm_src_store.sv @@
// per-source seen bits and latest departure memory with write-to-read bypass
module alrm_src_store (
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_en,
  input  alrm_pkg::src_t     rd_src,
  input  logic               upd_en,
  input  alrm_pkg::src_t     upd_src,
  input  alrm_pkg::time_t    upd_latest,
  output alrm_pkg::src_look_t look
);
  import alrm_pkg::*;

  time_t              mem [SOURCES];
  logic [SOURCES-1:0] seen;
  time_t              rd_data;
  logic               byp;
  time_t              byp_val;

  always_ff @(posedge clk) begin
    if (upd_en) begin
      mem[upd_src] <= upd_latest;
    end
    if (rd_en) begin
      rd_data <= mem[rd_src];
      byp     <= upd_en && (upd_src == rd_src);
      byp_val <= upd_latest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (upd_en) begin
      seen[upd_src] <= 1'b1;
    end
  end

  always_comb begin
    look.seen = seen[upd_src];
    if (!look.seen) begin
      look.latest = '0;
    end else if (byp) begin
      look.latest = byp_val;
    end else begin
      look.latest = rd_data;
    end
  end

endmodule

@@ src/alrm_stats.sv @@
// running min and max latency and saturating event counters
module alrm_stats (
  input  logic                clk,
  input  logic                rst,
  input  alrm_pkg::stat_upd_t upd,
  output alrm_pkg::stat_out_t stats
);
  import alrm_pkg::*;

  stat_out_t stats_next;
  logic      first;

  always_comb begin
    stats_next = stats;
    first      = (stats.delivered == '0);
    if (upd.fire) begin
      if (stats.delivered != '1) begin
        stats_next.delivered = stats.delivered + cnt_t'(1);
      end
      if (first) begin
        stats_next.min_lat = upd.lat;
        stats_next.max_lat = upd.lat;
      end else begin
        if ($signed(upd.lat) < $signed(stats.min_lat)) begin
          stats_next.min_lat = upd.lat;
        end
        if ($signed(stats.max_lat) < $signed(upd.lat)) begin
          stats_next.max_lat = upd.lat;
        end
      end
      if (upd.pair && stats.pairs != '1) begin
        stats_next.pairs = stats.pairs + cnt_t'(1);
      end
      if (upd.inv && stats.inversions != '1) begin
        stats_next.inversions = stats.inversions + cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stats <= '0;
    end else begin
      stats <= stats_next;
    end
  end

endmodule

@@ src/arrival_latency_and_reorder_monitor_top.sv @@
// top level: input register, per-source lookup, stats and result register
// result: each accepted word passes the input register, then the result register
// throughput: one word per cycle while the result word is not held by m_tready
// back-to-back words from one source are served by a bypass around the memory
// reset: synchronous, clears valids, all seen bits and the statistics
// no clearing pass: the store is usable as soon as reset is released
module arrival_latency_and_reorder_monitor_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // arrival time, depart_time, source index
  input  logic [alrm_pkg::IN_W-1:0] s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // latency, min_latency, max_latency, delivered_count, pair_count,
  // inversion_count, zero fill
  output logic [alrm_pkg::OUT_W-1:0] m_tdata,
  // is_inversion
  output logic                      m_tuser
);
  import alrm_pkg::*;

  logic      s1_valid;
  time_t     s1_arr;
  time_t     s1_dep;
  src_t      s1_src;
  logic      s1_fire;
  logic      in_fire;
  src_t      in_src;
  src_look_t look;
  lat_t      lat;
  logic      inv;
  time_t     new_latest;
  stat_upd_t upd;
  stat_out_t stats;
  lat_t      out_lat;
  logic      out_inv;

  assign in_src   = s_tdata[2*TIME_BITS +: SRC_BITS];
  assign s1_fire  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_fire;
  assign in_fire  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_arr <= s_tdata[0 +: TIME_BITS];
      s1_dep <= s_tdata[TIME_BITS +: TIME_BITS];
      s1_src <= in_src;
    end
  end

  alrm_src_store u_store (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (in_fire),
    .rd_src     (in_src),
    .upd_en     (s1_fire),
    .upd_src    (s1_src),
    .upd_latest (new_latest),
    .look       (look)
  );

  assign lat        = {1'b0, s1_arr} - {1'b0, s1_dep};
  assign inv        = look.seen && (s1_dep < look.latest);
  assign new_latest = (s1_dep > look.latest) ? s1_dep : look.latest;

  assign upd.fire = s1_fire;
  assign upd.lat  = lat;
  assign upd.pair = look.seen;
  assign upd.inv  = inv;

  alrm_stats u_stats (
    .clk   (clk),
    .rst   (rst),
    .upd   (upd),
    .stats (stats)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_lat <= lat;
      out_inv <= inv;
    end
  end

  assign m_tdata = {(OUT_W - OUT_BITS)'(0), stats.inversions, stats.pairs, stats.delivered,
                    stats.max_lat, stats.min_lat, out_lat};
  assign m_tuser = out_inv;

endmodule

@@ src/alrm_checker.sv @@
// port-level checks for the monitor top, attached by bind
module alrm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [alrm_pkg::OUT_W-1:0] m_tdata,
  input logic                       m_tuser
);
  import alrm_pkg::*;

  lat_t min_l;
  lat_t max_l;
  cnt_t dlv;
  cnt_t prs;
  cnt_t invs;

  assign min_l = m_tdata[LAT_BITS +: LAT_BITS];
  assign max_l = m_tdata[2*LAT_BITS +: LAT_BITS];
  assign dlv   = m_tdata[3*LAT_BITS +: CNT_BITS];
  assign prs   = m_tdata[3*LAT_BITS + CNT_BITS +: CNT_BITS];
  assign invs  = m_tdata[3*LAT_BITS + 2*CNT_BITS +: CNT_BITS];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  a_min_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $signed(min_l) <= $signed(max_l))
    else $error("min latency above max latency");

  a_counts: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> invs <= prs && prs < dlv)
    else $error("counter ordering broken");

  a_inv: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> invs != '0)
    else $error("inversion flagged but not counted");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind arrival_latency_and_reorder_monitor_top alrm_checker u_alrm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
